/* src/hsg_pkg.sv */
// Shared types and constants for the household SIS event block.
`default_nettype none
package hsg_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RATE_W = 24;
    localparam int SUM_RATE_W = 26;
    localparam int LN_W = 38;
    localparam int SEED_DIV = 5;
    localparam int SEED_SHIFT = 22;
    localparam int SEED_MUL = ((1 << SEED_SHIFT) + SEED_DIV - 1) / SEED_DIV;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ALPHA = 3'd0;
    localparam cfg_idx_t CFG_BETA = 3'd1;
    localparam cfg_idx_t CFG_GAMMA = 3'd2;
    localparam cfg_idx_t CFG_HOUSES = 3'd3;
    localparam cfg_idx_t CFG_OBSERVE = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;
    localparam logic KIND_INFECT = 1'b0;
    localparam logic KIND_RECOVER = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEEDCALC,
        ST_SEED,
        ST_SUM,
        ST_EPSMUL,
        ST_EPSGO,
        ST_EPSDIV,
        ST_TOT0,
        ST_TOT1,
        ST_TOT2,
        ST_TOT3,
        ST_PICK0,
        ST_PICK1,
        ST_PICK2,
        ST_SCAN,
        ST_FETCH,
        ST_FETCHW,
        ST_APPLY,
        ST_DTGO,
        ST_DTDIV,
        ST_OUT
    } hsg_state_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_NORM,
        LN_LOOK,
        LN_MUL,
        LN_SCALE,
        LN_SUB
    } hsg_ln_state_t;

endpackage
`default_nettype wire

/* src/hsg_mem.sv */
// Household state memory, one write port and one registered read port.
`default_nettype none
module hsg_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [1:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [1:0]               rdata
);

    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/hsg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module hsg_div #(
    parameter int W = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        trial     = {rem_reg[W-1:0], q_reg[W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(W);
            rem_next  = '0;
            q_next    = num;
            d_next    = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

/* src/hsg_ln.sv */
// Negative natural log of a 32-bit fraction, table lookup with interpolation.
`default_nettype none
module hsg_ln #(
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             u,
    output logic                    done,
    output logic [hsg_pkg::LN_W-1:0] value
);

    import hsg_pkg::*;

    localparam int LG = $clog2(LOG_TABLE_DEPTH);

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] ln_entry(input int unsigned i);
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] k;
        den  = 64'(2 * LOG_TABLE_DEPTH) + 64'(i);
        z    = udiv64(64'(i) << 32, den);
        zz   = (z * z) >> 32;
        term = z;
        acc  = '0;
        k    = 64'd1;
        for (int s = 0; s < 48; s++)
        begin
            if (term != 0)
            begin
                acc  = acc + udiv64(term, k);
                term = (term * zz) >> 32;
                k    = k + 64'd2;
            end
        end
        return 32'(acc << 1);
    endfunction

    logic [31:0] ln_tab [LOG_TABLE_DEPTH+1];

    for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++)
    begin : g_tab
        localparam logic [31:0] ENTRY = ln_entry(g);
        assign ln_tab[g] = ENTRY;
    end

    localparam logic [31:0] TOP = ln_entry(LOG_TABLE_DEPTH);

    hsg_ln_state_t   st_reg, st_next;
    logic            done_reg, done_next;
    logic [31:0]     m_reg, m_next;
    logic [4:0]      p_reg, p_next;
    logic [31:0]     lo_reg, lo_next;
    logic [31:0]     diff_reg, diff_next;
    logic [30:0]     rem_reg, rem_next;
    logic [62:0]     prod_reg, prod_next;
    logic [31:0]     l_reg, l_next;
    logic [LN_W-1:0] scl_reg, scl_next;
    logic [LN_W-1:0] value_reg, value_next;
    logic [LG-1:0]   idx;
    logic [31:0]     hi;
    logic [32:0]     l_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= LN_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        p_reg     <= p_next;
        lo_reg    <= lo_next;
        diff_reg  <= diff_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        l_reg     <= l_next;
        scl_reg   <= scl_next;
        value_reg <= value_next;
    end

    always_comb
    begin
        st_next    = st_reg;
        done_next  = done_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        lo_next    = lo_reg;
        diff_next  = diff_reg;
        rem_next   = rem_reg;
        prod_next  = prod_reg;
        l_next     = l_reg;
        scl_next   = scl_reg;
        value_next = value_reg;
        idx        = m_reg[30 -: LG];
        hi         = ln_tab[{1'b0, idx} + (LG+1)'(1)];
        l_sum      = {1'b0, lo_reg} + {1'b0, prod_reg[62:31]};
        unique case (st_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b0;
                    m_next    = (u == 32'd0) ? 32'd1 : u;
                    p_next    = 5'd31;
                    st_next   = LN_NORM;
                end
            end
            LN_NORM:
            begin
                if (m_reg[31])
                begin
                    st_next = LN_LOOK;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
            end
            LN_LOOK:
            begin
                lo_next   = ln_tab[{1'b0, idx}];
                diff_next = (hi > ln_tab[{1'b0, idx}]) ? hi - ln_tab[{1'b0, idx}] : 32'd0;
                rem_next  = {m_reg[30-LG:0], {LG{1'b0}}};
                st_next   = LN_MUL;
            end
            LN_MUL:
            begin
                prod_next = diff_reg * rem_reg;
                st_next   = LN_SCALE;
            end
            LN_SCALE:
            begin
                l_next   = (l_sum > {1'b0, TOP}) ? TOP : l_sum[31:0];
                scl_next = LN_W'((6'd32 - {1'b0, p_reg}) * TOP);
                st_next  = LN_SUB;
            end
            LN_SUB:
            begin
                value_next = scl_reg - LN_W'(l_reg);
                done_next  = 1'b1;
                st_next    = LN_IDLE;
            end
            default:
            begin
                st_next = LN_IDLE;
            end
        endcase
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

/* src/household_sis_gillespie_step.sv */
// Household SIS Gillespie event engine: house-state memory, rate sweep and prefix search.
// Each request is one event (or a start). An event reads the households in use from the state
// memory in two sweeps: one over every house to histogram the houses and sum the infected, and
// one that stops at the house whose running rate sum passes the pick. Between the sweeps a
// serial divider forms the global infection term, and after the update the same divider turns
// -ln(uniform_wait) into the wait. The divider is DW bits wide (40 at the default size). A start
// request, and the reseed after a die-out, sweeps all MAX_HOUSES memory entries, one per cycle.
// One request is worked at a time; the next is taken while the previous result waits on the output.
`default_nettype none
module household_sis_gillespie_step #(
    parameter int MAX_HOUSES = 1024,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [31:0]                     uniform_wait,
    input  logic [31:0]                     uniform_pick,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [9:0]                      house_index,
    output logic                            event_kind,
    output logic [11:0]                     total_infected,
    output logic [31:0]                     sim_time,
    output logic                            died_out,
    output logic                            observed,
    output logic [10:0]                     count_clear,
    output logic [10:0]                     count_single,
    output logic [10:0]                     count_double,
    output logic                            ignored,
    input  logic                            cfg_we,
    input  logic [hsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import hsg_pkg::*;

    localparam int AW = $clog2(MAX_HOUSES);
    localparam int HW = $clog2(MAX_HOUSES + 1);
    localparam int SW = HW + 1;
    localparam int RW = SUM_RATE_W;
    localparam int TW = HW + RW;
    localparam int DW = (TW > 40) ? TW : 40;
    localparam int MW = TW + 16;

    hsg_state_t     state_reg, state_next;
    logic [23:0]    alpha_reg, beta_reg, gamma_reg;
    logic [10:0]    hcount_reg;
    logic [31:0]    observe_reg;
    logic           run_reg, run_next;
    logic [31:0]    elapsed_reg, elapsed_next;
    logic           start_reg, start_next;
    logic [31:0]    upick_reg, upick_next;
    logic [HW-1:0]  hc_reg, hc_next, hc_eff;
    logic [HW-1:0]  seeds_reg, seeds_next;
    logic [HW-1:0]  sweep_reg, sweep_next;
    logic [HW-1:0]  rd_cnt_reg, rd_cnt_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [AW-1:0]  pidx_reg, pidx_next;
    logic [HW-1:0]  c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [SW-1:0]  isum_reg, isum_next;
    logic [23:0]    eps_reg, eps_next;
    logic [RW-1:0]  r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next;
    logic [MW-1:0]  mul_reg, mul_next;
    logic [MW-1:0]  mul2_reg, mul2_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [TW-1:0]  pick_reg, pick_next;
    logic [TW-1:0]  cum_reg, cum_next;
    logic [TW-1:0]  remain_reg, remain_next;
    logic [AW-1:0]  sel_reg, sel_next;
    logic [1:0]     selv_reg, selv_next;

    logic [9:0]     res_house_reg, res_house_next;
    logic           res_kind_reg, res_kind_next;
    logic [11:0]    res_total_reg, res_total_next;
    logic [31:0]    res_time_reg, res_time_next;
    logic           res_died_reg, res_died_next;
    logic           res_obs_reg, res_obs_next;
    logic [10:0]    res_c0_reg, res_c0_next, res_c1_reg, res_c1_next, res_c2_reg, res_c2_next;
    logic           res_ign_reg, res_ign_next;

    logic           out_valid_reg, out_valid_next;
    logic           out_load;
    logic [9:0]     o_house_reg;
    logic           o_kind_reg;
    logic [11:0]    o_total_reg;
    logic [31:0]    o_time_reg;
    logic           o_died_reg, o_obs_reg, o_ign_reg;
    logic [10:0]    o_c0_reg, o_c1_reg, o_c2_reg;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [1:0]     mem_wdata, mem_rdata;

    logic           div_start, div_done;
    logic [DW-1:0]  div_num, div_den, div_quo;
    logic           ln_start, ln_done;
    logic [LN_W-1:0] ln_value;

    logic [HW+SEED_SHIFT:0] seeds_prod;
    logic [24+SW-1:0]       eps_prod;
    logic [HW+RW-1:0]       tp0, tp1, tp2;
    logic [MW-1:0]          pa;
    logic [47:0]            pb;
    logic [RW-1:0]          rate_d, inf_sel;
    logic [TW-1:0]          cum_sum;
    logic [DW:0]            nt;
    logic [1:0]             new_v;
    logic [SW-1:0]          isum_new;

    hsg_mem #(
        .DEPTH (MAX_HOUSES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hsg_div #(
        .W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    hsg_ln #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .u     (uniform_wait),
        .done  (ln_done),
        .value (ln_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 24'd65536;
            beta_reg    <= 24'd6554;
            gamma_reg   <= 24'd9830;
            hcount_reg  <= 11'd1024;
            observe_reg <= 32'd65536000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA:   alpha_reg   <= cfg_data[23:0];
                CFG_BETA:    beta_reg    <= cfg_data[23:0];
                CFG_GAMMA:   gamma_reg   <= cfg_data[23:0];
                CFG_HOUSES:  hcount_reg  <= cfg_data[10:0];
                CFG_OBSERVE: observe_reg <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        upick_reg      <= upick_next;
        hc_reg         <= hc_next;
        seeds_reg      <= seeds_next;
        sweep_reg      <= sweep_next;
        rd_cnt_reg     <= rd_cnt_next;
        pidx_reg       <= pidx_next;
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        c2_reg         <= c2_next;
        isum_reg       <= isum_next;
        eps_reg        <= eps_next;
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        r2_reg         <= r2_next;
        mul_reg        <= mul_next;
        mul2_reg       <= mul2_next;
        total_reg      <= total_next;
        pick_reg       <= pick_next;
        cum_reg        <= cum_next;
        remain_reg     <= remain_next;
        sel_reg        <= sel_next;
        selv_reg       <= selv_next;
        res_house_reg  <= res_house_next;
        res_kind_reg   <= res_kind_next;
        res_total_reg  <= res_total_next;
        res_time_reg   <= res_time_next;
        res_died_reg   <= res_died_next;
        res_obs_reg    <= res_obs_next;
        res_c0_reg     <= res_c0_next;
        res_c1_reg     <= res_c1_next;
        res_c2_reg     <= res_c2_next;
        res_ign_reg    <= res_ign_next;
        if (out_load)
        begin
            o_house_reg <= res_house_reg;
            o_kind_reg  <= res_kind_reg;
            o_total_reg <= res_total_reg;
            o_time_reg  <= res_time_reg;
            o_died_reg  <= res_died_reg;
            o_obs_reg   <= res_obs_reg;
            o_c0_reg    <= res_c0_reg;
            o_c1_reg    <= res_c1_reg;
            o_c2_reg    <= res_c2_reg;
            o_ign_reg   <= res_ign_reg;
        end
    end

    always_comb
    begin
        if (hcount_reg == 11'd0)
        begin
            hc_eff = HW'(1);
        end
        else if (32'(hcount_reg) > MAX_HOUSES)
        begin
            hc_eff = HW'(MAX_HOUSES);
        end
        else
        begin
            hc_eff = HW'(hcount_reg);
        end
    end

    assign seeds_prod = (HW+SEED_SHIFT+1)'(hc_reg) * (HW+SEED_SHIFT+1)'(SEED_MUL);
    assign eps_prod   = alpha_reg * isum_reg;
    assign tp0        = c0_reg * r0_reg;
    assign tp1        = c1_reg * r1_reg;
    assign tp2        = c2_reg * r2_reg;
    assign pa         = total_reg[TW-1:16] * upick_reg;
    assign pb         = total_reg[15:0] * upick_reg;
    assign cum_sum    = cum_reg + TW'(rate_d);
    assign nt         = (DW+1)'(elapsed_reg) + (DW+1)'(div_quo);

    always_comb
    begin
        case (mem_rdata)
            2'd0:    rate_d = r0_reg;
            2'd1:    rate_d = r1_reg;
            2'd2:    rate_d = r2_reg;
            default: rate_d = '0;
        endcase
        case (selv_reg)
            2'd0:    inf_sel = r0_reg;
            2'd1:    inf_sel = RW'(eps_reg) + RW'(beta_reg);
            default: inf_sel = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        run_next       = run_reg;
        elapsed_next   = elapsed_reg;
        start_next     = start_reg;
        upick_next     = upick_reg;
        hc_next        = hc_reg;
        seeds_next     = seeds_reg;
        sweep_next     = sweep_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        pidx_next      = pidx_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        isum_next      = isum_reg;
        eps_next       = eps_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        mul_next       = mul_reg;
        mul2_next      = mul2_reg;
        total_next     = total_reg;
        pick_next      = pick_reg;
        cum_next       = cum_reg;
        remain_next    = remain_reg;
        sel_next       = sel_reg;
        selv_next      = selv_reg;
        res_house_next = res_house_reg;
        res_kind_next  = res_kind_reg;
        res_total_next = res_total_reg;
        res_time_next  = res_time_reg;
        res_died_next  = res_died_reg;
        res_obs_next   = res_obs_reg;
        res_c0_next    = res_c0_reg;
        res_c1_next    = res_c1_reg;
        res_c2_next    = res_c2_reg;
        res_ign_next   = res_ign_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg[AW-1:0];
        mem_wdata      = 2'd0;
        mem_raddr      = rd_cnt_reg[AW-1:0];
        div_start      = 1'b0;
        div_num        = DW'(mul_reg);
        div_den        = DW'({hc_reg, 1'b0});
        ln_start       = 1'b0;
        new_v          = selv_reg;
        isum_new       = isum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hc_next        = hc_eff;
                    upick_next     = uniform_pick;
                    res_house_next = '0;
                    res_kind_next  = KIND_INFECT;
                    res_total_next = '0;
                    res_time_next  = '0;
                    res_died_next  = 1'b0;
                    res_obs_next   = 1'b0;
                    res_c0_next    = '0;
                    res_c1_next    = '0;
                    res_c2_next    = '0;
                    res_ign_next   = 1'b0;
                    if (operation == OP_START)
                    begin
                        start_next = 1'b1;
                        state_next = ST_SEEDCALC;
                    end
                    else if (!run_reg)
                    begin
                        res_ign_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        start_next    = 1'b0;
                        res_time_next = elapsed_reg;
                        ln_start      = 1'b1;
                        rd_cnt_next   = '0;
                        c0_next       = '0;
                        c1_next       = '0;
                        c2_next       = '0;
                        isum_next     = '0;
                        state_next    = ST_SUM;
                    end
                end
            end
            ST_SEEDCALC:
            begin
                seeds_next = HW'(seeds_prod >> SEED_SHIFT);
                sweep_next = '0;
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                mem_we     = 1'b1;
                mem_wdata  = (sweep_reg < seeds_reg) ? 2'd1 : 2'd0;
                sweep_next = sweep_reg + HW'(1);
                if (sweep_reg == HW'(MAX_HOUSES - 1))
                begin
                    elapsed_next = '0;
                    if (start_reg)
                    begin
                        run_next       = 1'b1;
                        res_total_next = 12'(seeds_reg);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_SUM:
            begin
                if (rd_cnt_reg < hc_reg)
                begin
                    rd_cnt_next  = rd_cnt_reg + HW'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    isum_next = isum_reg + SW'(mem_rdata);
                    case (mem_rdata)
                        2'd0:    c0_next = c0_reg + HW'(1);
                        2'd1:    c1_next = c1_reg + HW'(1);
                        2'd2:    c2_next = c2_reg + HW'(1);
                        default: ;
                    endcase
                end
                if (rd_cnt_reg == hc_reg && !rd_pend_reg)
                begin
                    state_next = ST_EPSMUL;
                end
            end
            ST_EPSMUL:
            begin
                mul_next   = MW'(eps_prod);
                state_next = ST_EPSGO;
            end
            ST_EPSGO:
            begin
                div_start  = 1'b1;
                state_next = ST_EPSDIV;
            end
            ST_EPSDIV:
            begin
                if (div_done)
                begin
                    eps_next   = div_quo[23:0];
                    r0_next    = RW'({div_quo[23:0], 1'b0});
                    r1_next    = RW'(div_quo[23:0]) + RW'(beta_reg) + RW'(gamma_reg);
                    r2_next    = RW'({gamma_reg, 1'b0});
                    state_next = ST_TOT0;
                end
            end
            ST_TOT0:
            begin
                mul_next   = MW'(tp0);
                state_next = ST_TOT1;
            end
            ST_TOT1:
            begin
                total_next = TW'(mul_reg);
                mul_next   = MW'(tp1);
                state_next = ST_TOT2;
            end
            ST_TOT2:
            begin
                total_next = total_reg + TW'(mul_reg);
                mul_next   = MW'(tp2);
                state_next = ST_TOT3;
            end
            ST_TOT3:
            begin
                total_next = total_reg + TW'(mul_reg);
                state_next = ST_PICK0;
            end
            ST_PICK0:
            begin
                if (total_reg == '0)
                begin
                    res_total_next = 12'(isum_reg);
                    res_obs_next   = 1'b1;
                    res_c0_next    = 11'(c0_reg);
                    res_c1_next    = 11'(c1_reg);
                    res_c2_next    = 11'(c2_reg);
                    run_next       = 1'b0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    mul_next   = pa;
                    state_next = ST_PICK1;
                end
            end
            ST_PICK1:
            begin
                mul2_next  = MW'(pb >> 16);
                state_next = ST_PICK2;
            end
            ST_PICK2:
            begin
                pick_next   = TW'((mul_reg + mul2_reg) >> 16);
                cum_next    = '0;
                rd_cnt_next = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rd_cnt_reg < hc_reg)
                begin
                    rd_cnt_next  = rd_cnt_reg + HW'(1);
                    rd_pend_next = 1'b1;
                    pidx_next    = rd_cnt_reg[AW-1:0];
                end
                if (rd_pend_reg)
                begin
                    if (cum_sum > pick_reg)
                    begin
                        sel_next     = pidx_reg;
                        selv_next    = mem_rdata;
                        remain_next  = pick_reg - cum_reg;
                        rd_pend_next = 1'b0;
                        state_next   = ST_APPLY;
                    end
                    else
                    begin
                        cum_next = cum_sum;
                    end
                end
                else if (rd_cnt_reg == hc_reg)
                begin
                    sel_next    = '0;
                    remain_next = '0;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                mem_raddr  = '0;
                state_next = ST_FETCHW;
            end
            ST_FETCHW:
            begin
                selv_next  = mem_rdata;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (TW'(inf_sel) > remain_reg)
                begin
                    if (selv_reg < 2'd2)
                    begin
                        new_v    = selv_reg + 2'd1;
                        isum_new = isum_reg + SW'(1);
                    end
                end
                else
                begin
                    res_kind_next = KIND_RECOVER;
                    if (selv_reg > 2'd0)
                    begin
                        new_v    = selv_reg - 2'd1;
                        isum_new = isum_reg - SW'(1);
                    end
                end
                if (new_v != selv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sel_reg;
                    mem_wdata = new_v;
                    case (selv_reg)
                        2'd0:    c0_next = c0_reg - HW'(1);
                        2'd1:    c1_next = c1_reg - HW'(1);
                        default: c2_next = c2_reg - HW'(1);
                    endcase
                    case (new_v)
                        2'd0:    c0_next = c0_reg + HW'(1);
                        2'd1:    c1_next = c1_reg + HW'(1);
                        default: c2_next = c2_reg + HW'(1);
                    endcase
                end
                isum_next      = isum_new;
                res_house_next = 10'(sel_reg);
                res_total_next = 12'(isum_new);
                if (isum_new == '0)
                begin
                    res_died_next = 1'b1;
                    start_next    = 1'b0;
                    state_next    = ST_SEEDCALC;
                end
                else
                begin
                    state_next = ST_DTGO;
                end
            end
            ST_DTGO:
            begin
                div_num = DW'(ln_value);
                div_den = DW'(total_reg);
                if (ln_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DTDIV;
                end
            end
            ST_DTDIV:
            begin
                if (div_done)
                begin
                    if (nt > (DW+1)'(observe_reg))
                    begin
                        res_obs_next = 1'b1;
                        res_c0_next  = 11'(c0_reg);
                        res_c1_next  = 11'(c1_reg);
                        res_c2_next  = 11'(c2_reg);
                        run_next     = 1'b0;
                    end
                    else
                    begin
                        elapsed_next = nt[31:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign house_index    = o_house_reg;
    assign event_kind     = o_kind_reg;
    assign total_infected = o_total_reg;
    assign sim_time       = o_time_reg;
    assign died_out       = o_died_reg;
    assign observed       = o_obs_reg;
    assign count_clear    = o_c0_reg;
    assign count_single   = o_c1_reg;
    assign count_double   = o_c2_reg;
    assign ignored        = o_ign_reg;

endmodule
`default_nettype wire

/* src/hsg_check.sv */
// Port-level checker for the household SIS event block, bound to the top level.
`default_nettype none
module hsg_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  house_index,
    input logic        event_kind,
    input logic [11:0] total_infected,
    input logic [31:0] sim_time,
    input logic        died_out,
    input logic        observed,
    input logic        ignored
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(house_index) && $stable(sim_time)
            && $stable(total_infected))
        else $error("result changed while stalled");

    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ignored |-> house_index == 10'd0 && total_infected == 12'd0
            && !observed && !died_out && !event_kind && sim_time == 32'd0)
        else $error("ignored result carries data");

    a_died: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && died_out |-> total_infected == 12'd0 && !observed && !ignored)
        else $error("die-out result inconsistent");

    a_observed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && observed |-> !died_out && !ignored)
        else $error("observation result inconsistent");

endmodule

bind household_sis_gillespie_step hsg_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .house_index    (house_index),
    .event_kind     (event_kind),
    .total_infected (total_infected),
    .sim_time       (sim_time),
    .died_out       (died_out),
    .observed       (observed),
    .ignored        (ignored)
);
`default_nettype wire

/* bench/household_sis_gillespie_step_tb.sv */
// Self-checking testbench for the household SIS event block, with its own event predictor.
`default_nettype none
module household_sis_gillespie_step_tb;
    import hsg_pkg::*;

    localparam int HOUSES_MAX = 1024;
    localparam int LN_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRESSURE_HOLD = 4000;
    localparam int RANDOM_ITEMS = 290;

    typedef struct packed {
        logic [9:0]  house;
        logic        kind;
        logic [11:0] infected;
        logic [31:0] at_time;
        logic        died;
        logic        obs;
        logic [10:0] n_clear;
        logic [10:0] n_single;
        logic [10:0] n_double;
        logic        ign;
    } event_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [31:0] uniform_wait;
    logic [31:0] uniform_pick;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  house_index;
    logic        event_kind;
    logic [11:0] total_infected;
    logic [31:0] sim_time;
    logic        died_out;
    logic        observed;
    logic [10:0] count_clear;
    logic [10:0] count_single;
    logic [10:0] count_double;
    logic        ignored;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    household_sis_gillespie_step i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .uniform_wait(uniform_wait), .uniform_pick(uniform_pick),
        .out_valid(out_valid), .out_stall(out_stall),
        .house_index(house_index), .event_kind(event_kind), .total_infected(total_infected),
        .sim_time(sim_time), .died_out(died_out), .observed(observed),
        .count_clear(count_clear), .count_single(count_single), .count_double(count_double),
        .ignored(ignored),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint unsigned alpha_r, beta_r, gamma_r, houses_r, observe_r;
    byte unsigned    house_inf [HOUSES_MAX];
    int unsigned     sum_infected;
    longint unsigned now_time;
    bit              run_on;
    longint unsigned ln_tab [LN_DEPTH+1];

    event_result_t expected_events [$];
    int errors;
    int requests_sent;
    int results_seen;
    int n_observed;
    int n_died;
    int n_ignored;
    int idle_cycles;
    bit quiet;
    bit hold_req;
    int stall_left;

    function automatic longint unsigned ln1p_entry(longint unsigned i);
        longint unsigned den, z, zz, term, acc, k;
        den = 2 * LN_DEPTH + i;
        z = (i << 32) / den;
        zz = (z * z) >> 32;
        term = z;
        acc = 0;
        k = 1;
        while (term != 0)
        begin
            acc += term / k;
            term = (term * zz) >> 32;
            k += 2;
        end
        return 2 * acc;
    endfunction

    function automatic longint unsigned wait_log(logic [31:0] u);
        int p;
        longint unsigned m, frac, pos, idx, rem, lo, hi, l, top;
        if (u == 0)
            u = 1;
        p = 31;
        while (!u[p])
            p--;
        m = longint'(u) << (31 - p);
        frac = m - 64'h8000_0000;
        pos = frac * LN_DEPTH;
        idx = pos >> 31;
        if (idx > LN_DEPTH - 1)
            idx = LN_DEPTH - 1;
        rem = pos & 64'h7FFF_FFFF;
        lo = ln_tab[idx];
        hi = ln_tab[idx + 1];
        l = lo + ((hi > lo) ? (((hi - lo) * rem) >> 31) : 0);
        top = ln_tab[LN_DEPTH];
        if (l > top)
            l = top;
        return longint'(32 - p) * top - l;
    endfunction

    function automatic int unsigned houses_used();
        if (houses_r == 0)
            return 1;
        if (houses_r > HOUSES_MAX)
            return HOUSES_MAX;
        return houses_r;
    endfunction

    function automatic void reseed_houses();
        int unsigned seeds;
        seeds = houses_used() / 5;
        for (int i = 0; i < HOUSES_MAX; i++)
            house_inf[i] = (i < seeds) ? 1 : 0;
        sum_infected = seeds;
        now_time = 0;
    endfunction

    function automatic void house_rates(int unsigned h, longint unsigned eps,
                                        output longint unsigned inf_r,
                                        output longint unsigned rec_r);
        longint unsigned n;
        n = house_inf[h];
        inf_r = (eps + beta_r * n) * ((n < 2) ? (2 - n) : 0);
        rec_r = gamma_r * n;
    endfunction

    function automatic void take_census(int unsigned hc, inout event_result_t r);
        int unsigned c0, c1, c2;
        c0 = 0;
        c1 = 0;
        c2 = 0;
        for (int i = 0; i < hc; i++)
        begin
            if (house_inf[i] == 0) c0++;
            else if (house_inf[i] == 1) c1++;
            else if (house_inf[i] == 2) c2++;
        end
        r.obs = 1'b1;
        r.n_clear = c0[10:0];
        r.n_single = c1[10:0];
        r.n_double = c2[10:0];
        run_on = 1'b0;
    endfunction

    function automatic event_result_t model_event(logic op, logic [31:0] u1, logic [31:0] u2);
        event_result_t r;
        int unsigned hc, isum, sel;
        longint unsigned eps, total, pick, cum, remain, inf_r, rec_r, dt, nt, u2w;
        r = '0;
        if (op == OP_START)
        begin
            reseed_houses();
            run_on = 1'b1;
            r.infected = sum_infected[11:0];
            return r;
        end
        if (!run_on)
        begin
            r.ign = 1'b1;
            return r;
        end
        hc = houses_used();
        isum = 0;
        for (int i = 0; i < hc; i++)
            isum += house_inf[i];
        eps = alpha_r * isum / (longint'(hc) * 2);
        total = 0;
        for (int i = 0; i < hc; i++)
        begin
            house_rates(i, eps, inf_r, rec_r);
            total += inf_r + rec_r;
        end
        r.at_time = now_time[31:0];
        if (total == 0)
        begin
            r.infected = isum[11:0];
            take_census(hc, r);
            return r;
        end
        u2w = u2;
        pick = ((total >> 16) * u2w + (((total & 64'hFFFF) * u2w) >> 16)) >> 16;
        sel = 0;
        remain = 0;
        cum = 0;
        for (int i = 0; i < hc; i++)
        begin
            house_rates(i, eps, inf_r, rec_r);
            if (cum + inf_r + rec_r > pick)
            begin
                sel = i;
                remain = pick - cum;
                break;
            end
            cum += inf_r + rec_r;
        end
        house_rates(sel, eps, inf_r, rec_r);
        if (inf_r > remain)
        begin
            if (house_inf[sel] < 2)
            begin
                house_inf[sel]++;
                isum++;
            end
        end
        else
        begin
            if (house_inf[sel] > 0)
            begin
                house_inf[sel]--;
                isum--;
            end
            r.kind = KIND_RECOVER;
        end
        r.house = sel[9:0];
        r.infected = isum[11:0];
        if (isum == 0)
        begin
            reseed_houses();
            r.died = 1'b1;
            return r;
        end
        sum_infected = isum;
        dt = wait_log(u1) / total;
        nt = now_time + dt;
        if (nt > observe_r)
            take_census(hc, r);
        else
            now_time = nt;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 300);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = PRESSURE_HOLD;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                      : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        event_result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{house_index, event_kind, total_infected, sim_time, died_out, observed,
                    count_clear, count_single, count_double, ignored};
            results_seen++;
            n_observed += observed;
            n_died += died_out;
            n_ignored += ignored;
            if (expected_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d results still expected", expected_events.size());
            $display("household_sis_gillespie_step_tb: errors");
            $finish;
        end
    end

    task automatic send_request(logic op, logic [31:0] u1, logic [31:0] u2);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation <= op;
        uniform_wait <= u1;
        uniform_pick <= u2;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_events.push_back(model_event(op, u1, u2));
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ALPHA:   alpha_r = value[23:0];
            CFG_BETA:    beta_r = value[23:0];
            CFG_GAMMA:   gamma_r = value[23:0];
            CFG_HOUSES:  houses_r = value[10:0];
            CFG_OBSERVE: observe_r = value;
            default: ;
        endcase
    endtask

    task automatic set_model(logic [31:0] a, logic [31:0] b, logic [31:0] g,
                             logic [31:0] h, logic [31:0] t);
        drain();
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_BETA, b);
        write_reg(CFG_GAMMA, g);
        write_reg(CFG_HOUSES, h);
        write_reg(CFG_OBSERVE, t);
    endtask

    task automatic send_event();
        send_request(OP_EVENT, $urandom, $urandom);
    endtask

    task automatic test_no_run();
        send_request(OP_EVENT, 32'd0, 32'd0);
        send_request(OP_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_default_size();
        send_request(OP_START, 32'd0, 32'd0);
        send_request(OP_EVENT, 32'd1, 32'd0);
        send_request(OP_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_EVENT, 32'd0, 32'h8000_0000);
    endtask

    task automatic test_house_limits();
        set_model(65536, 6554, 9830, 0, 65536000);
        send_request(OP_START, $urandom, $urandom);
        send_event();
        set_model(65536, 6554, 9830, 4, 65536000);
        send_request(OP_START, $urandom, $urandom);
        send_event();
        set_model(65536, 6554, 9830, 2047, 65536000);
        send_request(OP_START, $urandom, $urandom);
        send_event();
    endtask

    task automatic test_zero_rates();
        set_model(0, 0, 0, 10, 32'hFFFF_FFFF);
        send_request(OP_START, $urandom, $urandom);
        send_event();
        set_model(0, 0, 65536, 5, 32'hFFFF_FFFF);
        send_request(OP_START, $urandom, $urandom);
        send_event();
        send_event();
    endtask

    task automatic test_extreme_rates();
        set_model(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 20, 0);
        send_request(OP_START, $urandom, $urandom);
        send_event();
        send_event();
        set_model(24'hFF_FFFF, 24'hFF_FFFF, 1, 20, 32'hFFFF_FFFF);
        send_request(OP_START, $urandom, $urandom);
        repeat (3) send_event();
    endtask

    task automatic test_pressure();
        set_model(65536, 6554, 9830, 8, 32'hFFFF_FFFF);
        quiet = 1'b1;
        hold_req = 1'b1;
        send_request(OP_START, $urandom, $urandom);
        repeat (12) send_event();
        quiet = 1'b0;
    endtask

    task automatic test_random();
        int target, r;
        logic [31:0] a, b, g, h, t;
        target = requests_sent + RANDOM_ITEMS;
        while (requests_sent < target)
        begin
            r = $urandom_range(0, 9);
            a = (r == 0) ? 0 : (r == 1) ? 24'hFF_FFFF : $urandom_range(0, 4 * 65536);
            r = $urandom_range(0, 9);
            b = (r == 0) ? 0 : (r == 1) ? 24'hFF_FFFF : $urandom_range(0, 65536);
            r = $urandom_range(0, 9);
            g = (r == 0) ? 0 : (r == 1) ? 24'hFF_FFFF : $urandom_range(1, 2 * 65536);
            r = $urandom_range(0, 19);
            h = (r == 0) ? $urandom_range(0, 4) : (r == 1) ? $urandom_range(100, 2047)
                                                          : $urandom_range(5, 40);
            r = $urandom_range(0, 9);
            t = (r < 5) ? $urandom_range(0, 8 * 65536) : (r < 8) ? $urandom
                                                                 : ((r == 8) ? 0 : '1);
            set_model(a, b, g, h, t);
            if ($urandom_range(0, 4) != 0)
                send_request(OP_START, $urandom, $urandom);
            repeat ($urandom_range(5, 30))
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(OP_START, $urandom, $urandom);
                else
                    send_event();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i <= LN_DEPTH; i++)
            ln_tab[i] = ln1p_entry(i);
        alpha_r = 65536;
        beta_r = 6554;
        gamma_r = 9830;
        houses_r = 1024;
        observe_r = 65536000;
        for (int i = 0; i < HOUSES_MAX; i++)
            house_inf[i] = 0;
        sum_infected = 0;
        now_time = 0;
        run_on = 1'b0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        n_observed = 0;
        n_died = 0;
        n_ignored = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        stall_left = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        operation <= OP_START;
        uniform_wait <= '0;
        uniform_pick <= '0;
        out_stall <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ALPHA;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_run();
        test_default_size();
        test_house_limits();
        test_zero_rates();
        test_extreme_rates();
        test_pressure();
        test_random();

        drain();
        repeat (100) @(posedge clk);
        $display("%0d requests sent, %0d results checked", requests_sent, results_seen);
        $display("%0d observations, %0d die-outs, %0d ignored events",
                 n_observed, n_died, n_ignored);
        if (errors == 0 && expected_events.size() == 0)
            $display("household_sis_gillespie_step_tb: clean");
        else
            $display("household_sis_gillespie_step_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
